// ----- hw/rtl/mmfs_pkg.sv -----
package mmfs_pkg;

   localparam int MAX_FEATURES_DEF = 64;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int COUNT_BITS       = 7;
   localparam int INDEX_BITS       = 6;
   localparam int SCALE_BITS       = 16;
   localparam logic [SCALE_BITS-1:0] FULL_SCALE = 16'hFFFF;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      ACT_OBSERVE = 2'd0,
      ACT_SCALE   = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_UNSEEN = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]             action;
      logic [INDEX_BITS-1:0]  feature_index;
      logic signed [15:0]     sample_value;
   } req_type;

   typedef struct packed {
      logic [SCALE_BITS-1:0]  scaled_value;
      logic [INDEX_BITS-1:0]  feature_echo;
      logic [1:0]             status;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_DIVIDE,
      BK_OUTPUT
   } back_state_type;

   typedef struct packed {
      logic                   is_scale;
      logic                   is_error;
      logic [INDEX_BITS-1:0]  feature_index;
      logic signed [15:0]     sample_value;
   } job_type;

endpackage

// ----- hw/rtl/mmfs_front.sv -----
module mmfs_front #(
   parameter int MAX_FEATURES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [6:0]                 csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  mmfs_pkg::req_type          req_data,
   output logic                       job_valid,
   input  logic                       job_ready,
   output mmfs_pkg::job_type          job_data,
   output logic                       clear_pulse,
   input  logic                       back_busy
);
   import mmfs_pkg::*;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  q_valid_ff, q_valid_in;
   job_type               q_data_ff, q_data_in;
   logic                  in_range;
   logic                  take;
   logic                  out_done;
   job_type               job_new;
   logic                  emits;

   always_comb begin
      if (32'(count_ff) > MAX_FEATURES) begin
         in_range = 32'(req_data.feature_index) < MAX_FEATURES;
      end else begin
         in_range = {1'b0, req_data.feature_index} < count_ff;
      end
   end

   // A clear waits until no earlier item is still queued or in the back part.
   assign out_done  = !q_valid_ff || job_ready;
   assign req_ready = out_done &&
                      !(req_data.action == ACT_CLEAR && (q_valid_ff || back_busy));
   assign take      = req_valid && req_ready;

   always_comb begin
      job_new.is_scale      = req_data.action == ACT_SCALE;
      job_new.is_error      = !in_range;
      job_new.feature_index = req_data.feature_index;
      job_new.sample_value  = req_data.sample_value;
      emits = req_data.action == ACT_OBSERVE || req_data.action == ACT_SCALE;
      count_in   = csr_write_enable ? csr_write_data : count_ff;
      q_valid_in = q_valid_ff && !job_ready;
      q_data_in  = q_data_ff;
      if (take && emits) begin
         q_valid_in = 1'b1;
         q_data_in  = job_new;
      end
   end

   assign clear_pulse = take && req_data.action == ACT_CLEAR;
   assign job_valid   = q_valid_ff;
   assign job_data    = q_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= COUNT_RESET;
         q_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         q_valid_ff <= q_valid_in;
      end
      q_data_ff <= q_data_in;
   end

endmodule

// ----- hw/rtl/mmfs_back.sv -----
module mmfs_back #(
   parameter int MAX_FEATURES = 64,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  mmfs_pkg::job_type    job_data,
   input  logic                 clear_pulse,
   output logic                 back_busy,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mmfs_pkg::rsp_type    rsp_data
);
   import mmfs_pkg::*;

   localparam int ADDR_BITS = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int SPAN_BITS = SAMPLE_BITS + 1;
   localparam int NUM_BITS  = SPAN_BITS + SCALE_BITS;
   localparam int STEP_BITS = $clog2(NUM_BITS + 1);

   logic signed [SAMPLE_BITS-1:0] min_mem [MAX_FEATURES];
   logic signed [SAMPLE_BITS-1:0] max_mem [MAX_FEATURES];
   logic [MAX_FEATURES-1:0]       seen_ff, seen_in;

   back_state_type                state_ff, state_in;
   job_type                       job_ff, job_in;
   logic signed [SAMPLE_BITS-1:0] rd_min_ff, rd_max_ff;
   logic [NUM_BITS-1:0]           quo_ff, quo_in;
   logic [SPAN_BITS:0]            rem_ff, rem_in;
   logic [SPAN_BITS-1:0]          span_ff, span_in;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   rsp_type                       res_ff, res_in;
   rsp_type                       out_ff, out_in;
   logic                          out_valid_ff, out_valid_in;

   logic [ADDR_BITS-1:0]          addr;
   logic signed [SAMPLE_BITS-1:0] x;
   logic                          wr_en;
   logic signed [SAMPLE_BITS-1:0] wr_min, wr_max;
   logic [SPAN_BITS-1:0]          off;
   logic [SPAN_BITS:0]            rem_shift;

   assign addr = job_ff.feature_index[ADDR_BITS-1:0];
   assign x    = job_ff.sample_value[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         rd_min_ff <= min_mem[job_data.feature_index[ADDR_BITS-1:0]];
         rd_max_ff <= max_mem[job_data.feature_index[ADDR_BITS-1:0]];
      end
      if (wr_en) begin
         min_mem[addr] <= wr_min;
         max_mem[addr] <= wr_max;
      end
   end

   assign back_busy = state_ff != BK_IDLE;
   assign job_ready = state_ff == BK_IDLE;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      span_in      = span_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      seen_in      = seen_ff;
      wr_en        = 1'b0;
      wr_min       = x;
      wr_max       = x;
      off          = SPAN_BITS'(x) - SPAN_BITS'(rd_min_ff);
      rem_shift    = {rem_ff[SPAN_BITS-1:0], quo_ff[NUM_BITS-1]};
      if (clear_pulse) begin
         seen_in = '0;
      end
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_in   = job_data;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            res_in.feature_echo = job_ff.feature_index;
            res_in.scaled_value = '0;
            res_in.status       = ST_OK;
            state_in            = BK_OUTPUT;
            if (job_ff.is_error) begin
               res_in.status = ST_RANGE;
            end else if (!job_ff.is_scale) begin
               wr_en    = 1'b1;
               state_in = BK_IDLE;
               if (seen_ff[addr]) begin
                  wr_min = (x < rd_min_ff) ? x : rd_min_ff;
                  wr_max = (x > rd_max_ff) ? x : rd_max_ff;
               end
               seen_in[addr] = 1'b1;
            end else if (!seen_ff[addr]) begin
               res_in.status = ST_UNSEEN;
            end else if (rd_max_ff <= rd_min_ff || x <= rd_min_ff) begin
               res_in.scaled_value = '0;
            end else if (x >= rd_max_ff) begin
               res_in.scaled_value = FULL_SCALE;
            end else begin
               span_in  = SPAN_BITS'(rd_max_ff) - SPAN_BITS'(rd_min_ff);
               quo_in   = (NUM_BITS'(off) << SCALE_BITS) - NUM_BITS'(off);
               rem_in   = '0;
               step_in  = '0;
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (rem_shift >= {1'b0, span_ff}) begin
               rem_in = rem_shift - {1'b0, span_ff};
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (32'(step_ff) == NUM_BITS - 1) begin
               res_in.scaled_value = quo_in[SCALE_BITS-1:0];
               state_in            = BK_OUTPUT;
            end
         end
         BK_OUTPUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         seen_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
      end
      job_ff  <= job_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      span_ff <= span_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

endmodule

// ----- hw/rtl/minmax_feature_scaler_top.sv -----
// Per-feature min-max scaler. Requests arrive on the req_ channel as one
// transfer each: observe updates the stored minimum and maximum of a
// feature, scale returns (x - min) * 65535 / (max - min) as a Q0.16
// fraction, and clear forgets every feature. Results leave on the rsp_
// channel; observe produces none unless the feature is out of range, and
// clear never produces one. The csr_ port sets the number of features in use.
// The front part checks the range and queues one job; the back part reads
// the feature memories, updates them or runs a bit-serial divider.
// In the back part an observe passes through the read state only, an error
// or saturated scale through the read and output states, and a divided
// scale also through the 33 steps of the restoring divider, one quotient
// bit a cycle. One item is in the back part at a time while the next
// waits in the queue.
// Reset clears all seen bits and sets the feature count to 64.
// When the receiver stalls the result waits in the output register, the
// back part holds its next result, and the queue then fills and drops
// req_ready.
module minmax_feature_scaler_top #(
   parameter int MAX_FEATURES = mmfs_pkg::MAX_FEATURES_DEF,
   parameter int SAMPLE_BITS  = mmfs_pkg::SAMPLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [6:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  mmfs_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mmfs_pkg::rsp_type  rsp_data
);
   import mmfs_pkg::*;

   logic    job_valid, job_ready, clear_pulse, back_busy;
   job_type job_data;

   mmfs_front #(.MAX_FEATURES(MAX_FEATURES)) u_front (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_ready, .req_data,
      .job_valid, .job_ready, .job_data, .clear_pulse, .back_busy
   );

   mmfs_back #(.MAX_FEATURES(MAX_FEATURES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job_data,
      .clear_pulse, .back_busy, .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

// ----- hw/rtl/mmfs_checker.sv -----
module mmfs_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mmfs_pkg::rsp_type rsp_data
);
   import mmfs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result changed while stalled.");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.scaled_value == '0)
      else $error("Error result carries a value.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_UNSEEN)
      else $error("Unknown status code.");

endmodule

bind minmax_feature_scaler_top mmfs_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_data
);

// ----- dv/tb.sv -----
module tb;
   import mmfs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [6:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   minmax_feature_scaler_top dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int quiet_cycles = 0;
   logic req_taken = 1'b0;

   // Predictor state.
   logic [6:0] feature_limit = 7'd64;
   logic signed [15:0] learned_min[64];
   logic signed [15:0] learned_max[64];
   logic [63:0] learned_seen = '0;

   function automatic logic [15:0] scale_sample(logic signed [15:0] x,
                                                logic signed [15:0] lo,
                                                logic signed [15:0] hi);
      longint span;
      longint offset;
      if (hi <= lo) return 16'd0;
      if (x <= lo) return 16'd0;
      if (x >= hi) return FULL_SCALE;
      span = longint'(hi) - longint'(lo);
      offset = longint'(x) - longint'(lo);
      return 16'((offset * 65535) / span);
   endfunction

   task automatic predict_transfer(req_type r);
      rsp_type res;
      logic in_range;
      in_range = {1'b0, r.feature_index} < ((feature_limit > 7'd64) ? 7'd64 : feature_limit);
      res.scaled_value = '0;
      res.feature_echo = r.feature_index;
      res.status = ST_OK;
      case (action_type'(r.action))
         ACT_CLEAR: begin
            learned_seen = '0;
         end
         ACT_NONE: ;
         default: begin
            if (!in_range) begin
               res.status = ST_RANGE;
               expected_rsps.push_back(res);
            end else if (r.action == ACT_OBSERVE) begin
               if (!learned_seen[r.feature_index]) begin
                  learned_min[r.feature_index] = r.sample_value;
                  learned_max[r.feature_index] = r.sample_value;
                  learned_seen[r.feature_index] = 1'b1;
               end else begin
                  if (r.sample_value < learned_min[r.feature_index])
                     learned_min[r.feature_index] = r.sample_value;
                  if (r.sample_value > learned_max[r.feature_index])
                     learned_max[r.feature_index] = r.sample_value;
               end
            end else if (!learned_seen[r.feature_index]) begin
               res.status = ST_UNSEEN;
               expected_rsps.push_back(res);
            end else begin
               res.scaled_value = scale_sample(r.sample_value,
                  learned_min[r.feature_index], learned_max[r.feature_index]);
               expected_rsps.push_back(res);
            end
         end
      endcase
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Each input transfer is predicted at the edge that accepts it.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         predict_transfer(req_data);
      end
   end

   // Driver.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver side with its own long hold-off.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transfer, feature", rsp_data.feature_echo, -1);
         end else begin
            rsp_type want;
            want = expected_rsps.pop_front();
            if (rsp_data.scaled_value !== want.scaled_value)
               report_mismatch("scaled_value", rsp_data.scaled_value, want.scaled_value);
            if (rsp_data.feature_echo !== want.feature_echo)
               report_mismatch("feature_echo", rsp_data.feature_echo, want.feature_echo);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset ||
          hold_off_cycles > 0)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic req_type make_req(action_type act, int idx, int val);
      req_type r;
      r.action = act;
      r.feature_index = idx[5:0];
      r.sample_value = val[15:0];
      return r;
   endfunction

   task automatic drain();
      wait (pending_reqs.size() == 0);
      @(negedge clock);
      while (req_valid || expected_rsps.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(int value);
      csr_write_data <= value[6:0];
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      feature_limit = value[6:0];
   endtask

   // Random mix over nfeat features: mostly observes and scales, plus clears, no-ops and any-index requests.
   task automatic queue_random(int n, int nfeat);
      int idx;
      int val;
      for (int i = 0; i < n; i++) begin
         idx = $urandom_range(nfeat - 1);
         val = $urandom;
         case ($urandom_range(19))
            0: pending_reqs.push_back(make_req(ACT_CLEAR, idx, val));
            1: pending_reqs.push_back(make_req(ACT_NONE, idx, val));
            2: pending_reqs.push_back(make_req(action_type'($urandom_range(1)),
                                              $urandom_range(63), val));
            3, 4, 5, 6, 7, 8:
               pending_reqs.push_back(make_req(ACT_OBSERVE, idx, val));
            default: pending_reqs.push_back(make_req(ACT_SCALE, idx, val));
         endcase
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pending_reqs.push_back(make_req(ACT_SCALE, 0, 5));
      pending_reqs.push_back(make_req(ACT_OBSERVE, 0, -32768));
      pending_reqs.push_back(make_req(ACT_SCALE, 0, 100));
      pending_reqs.push_back(make_req(ACT_OBSERVE, 0, 32767));
      pending_reqs.push_back(make_req(ACT_SCALE, 0, -32768));
      pending_reqs.push_back(make_req(ACT_SCALE, 0, 32767));
      pending_reqs.push_back(make_req(ACT_SCALE, 0, 0));
      pending_reqs.push_back(make_req(ACT_SCALE, 0, -1));
      pending_reqs.push_back(make_req(ACT_OBSERVE, 63, 100));
      pending_reqs.push_back(make_req(ACT_SCALE, 63, 100));
      pending_reqs.push_back(make_req(ACT_OBSERVE, 5, 10));
      pending_reqs.push_back(make_req(ACT_OBSERVE, 5, 20));
      pending_reqs.push_back(make_req(ACT_SCALE, 5, 5));
      pending_reqs.push_back(make_req(ACT_SCALE, 5, 25));
      pending_reqs.push_back(make_req(ACT_SCALE, 5, 13));
      pending_reqs.push_back(make_req(ACT_NONE, 5, 13));
      pending_reqs.push_back(make_req(ACT_CLEAR, 0, 0));
      pending_reqs.push_back(make_req(ACT_SCALE, 5, 13));
      drain();

      write_count(1);
      pending_reqs.push_back(make_req(ACT_OBSERVE, 1, 7));
      pending_reqs.push_back(make_req(ACT_SCALE, 63, 7));
      pending_reqs.push_back(make_req(ACT_OBSERVE, 0, 7));
      pending_reqs.push_back(make_req(ACT_SCALE, 0, 7));
      drain();
      write_count(0);
      pending_reqs.push_back(make_req(ACT_OBSERVE, 0, 1));
      pending_reqs.push_back(make_req(ACT_SCALE, 0, 1));
      drain();
      write_count(127);
      pending_reqs.push_back(make_req(ACT_SCALE, 63, 1));
      drain();

      // Long receiver hold-off while items keep coming.
      hold_off_cycles = 400;
      queue_random(40, 4);
      drain();

      write_count(64);
      queue_random(150, 8);
      drain();
      send_idle_pct = 52;
      write_count(12);
      queue_random(150, 16);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 52;
      write_count(42);
      queue_random(150, 48);
      drain();
      send_idle_pct = 19;
      recv_stall_pct = 19;
      write_count(64);
      queue_random(200, 64);
      drain();

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
